// ----- rtl/lpad_pkg.sv -----
// Package with shared types and constants of the lookahead pair anomaly detector.
package lpad_pkg;

  localparam int unsigned SYSCALL_W = 9;
  localparam int unsigned TIME_W    = 64;
  localparam int unsigned MISS_W    = 4;
  localparam int unsigned FILL_W    = 4;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned FACTOR_W  = 8;
  localparam int unsigned LIMIT_W   = 16;
  localparam int unsigned WAIT_W    = 63;
  localparam int unsigned PROD_W    = CNT_W + FACTOR_W;

  // APB register map, one 64-bit register every 8 bytes.
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 64;

  localparam logic [1:0] REG_FACTOR     = 2'd0;
  localparam logic [1:0] REG_FACTOR_DEN = 2'd1;
  localparam logic [1:0] REG_LIMIT      = 2'd2;
  localparam logic [1:0] REG_WAIT       = 2'd3;

  localparam logic [FACTOR_W-1:0] FACTOR_RST     = 8'd128;
  localparam logic [FACTOR_W-1:0] FACTOR_DEN_RST = 8'd32;
  localparam logic [LIMIT_W-1:0]  LIMIT_RST      = 16'd30;
  localparam logic [WAIT_W-1:0]   WAIT_RST       = 63'd604800000000000;

  // One queued request as classified by the front end.
  typedef struct packed {
    logic                 is_clear;
    logic [SYSCALL_W-1:0] call;
    logic [TIME_W-1:0]    now;
  } lpad_item_t;

  // Configuration registers seen by the engine.
  typedef struct packed {
    logic [FACTOR_W-1:0] factor;
    logic [FACTOR_W-1:0] factor_den;
    logic [LIMIT_W-1:0]  limit;
    logic [WAIT_W-1:0]   wait_ns;
  } lpad_cfg_t;

  // Queue status toward the engine.
  typedef struct packed {
    logic       valid;
    lpad_item_t item;
  } lpad_head_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_SHIFT,
    ST_CNT_RD,
    ST_CNT_CHK,
    ST_CHECK,
    ST_LRN_RD,
    ST_LRN_WR,
    ST_MUL,
    ST_FREEZE,
    ST_DEADLINE
  } lpad_state_e;

endpackage

// ----- rtl/lookahead_pair_anomaly_detector.sv -----
// Top level: APB registers, request queue front end and detection engine.
//
// Requests arrive on a valid/ready channel: req_type_i 0 is a system call
// beat (syscall_num_i, now_time_i), req_type_i 1 empties the call window.
// Every request beat yields exactly one result beat on the output channel
// (mismatch count, anomaly flag, normal and frozen flags after the step).
// After reset the pair table is swept to zero, one entry per cycle, across
// all NUM_CALLS*NUM_CALLS entries (262144 at the defaults); no request is
// taken during the sweep, but register writes are. A two-entry queue sits
// in front of the engine and the result sits in an output register, so the
// sender keeps going while a result waits. A clear request is handled by
// the engine in its idle state. A call is popped, its call number reduced
// and the window shifted; each filled earlier slot is then looked up in the
// pair table, the checks run, and the pair bits are learned with a read and
// a write per slot when there were mismatches. All table accesses share the
// single port of the pair table memory. When the receiver stalls the engine
// takes no new item from the queue, which then fills and drops in_ready_o.
module lookahead_pair_anomaly_detector #(
  parameter int unsigned SEQ_LEN   = 9,
  parameter int unsigned NUM_CALLS = 512
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lpad_pkg::PADDR_W-1:0]   paddr,
  input  logic [lpad_pkg::PDATA_W-1:0]   pwdata,
  output logic [lpad_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          req_type_i,
  input  logic [lpad_pkg::SYSCALL_W-1:0] syscall_num_i,
  input  logic [lpad_pkg::TIME_W-1:0]    now_time_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lpad_pkg::MISS_W-1:0]    mismatch_count_o,
  output logic                          anomaly_flag_o,
  output logic                          normal_mode_o,
  output logic                          frozen_flag_o
);
  import lpad_pkg::*;

  lpad_cfg_t  cfg_q;
  lpad_head_t head;
  logic       pop;
  logic       busy;
  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[4:3];
  assign wr_en   = psel && penable && pwrite;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.factor     <= FACTOR_RST;
      cfg_q.factor_den <= FACTOR_DEN_RST;
      cfg_q.limit      <= LIMIT_RST;
      cfg_q.wait_ns    <= WAIT_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_FACTOR:     cfg_q.factor     <= pwdata[FACTOR_W-1:0];
        REG_FACTOR_DEN: cfg_q.factor_den <= pwdata[FACTOR_W-1:0];
        REG_LIMIT:      cfg_q.limit      <= pwdata[LIMIT_W-1:0];
        REG_WAIT:       cfg_q.wait_ns    <= pwdata[WAIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register reads.
  always_comb begin
    unique case (reg_sel)
      REG_FACTOR:     prdata = PDATA_W'(cfg_q.factor);
      REG_FACTOR_DEN: prdata = PDATA_W'(cfg_q.factor_den);
      REG_LIMIT:      prdata = PDATA_W'(cfg_q.limit);
      REG_WAIT:       prdata = PDATA_W'(cfg_q.wait_ns);
      default:        prdata = '0;
    endcase
  end

  lpad_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .syscall_num_i (syscall_num_i),
    .now_time_i    (now_time_i),
    .busy_i        (busy),
    .pop_i         (pop),
    .head_o        (head)
  );

  lpad_engine #(
    .SEQ_LEN   (SEQ_LEN),
    .NUM_CALLS (NUM_CALLS)
  ) u_engine (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .head_i           (head),
    .pop_o            (pop),
    .busy_o           (busy),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .mismatch_count_o (mismatch_count_o),
    .anomaly_flag_o   (anomaly_flag_o),
    .normal_mode_o    (normal_mode_o),
    .frozen_flag_o    (frozen_flag_o)
  );

endmodule

// ----- rtl/lpad_front.sv -----
// Front end: accepts request beats, classifies them and queues them for the engine.
module lpad_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          req_type_i,
  input  logic [lpad_pkg::SYSCALL_W-1:0] syscall_num_i,
  input  logic [lpad_pkg::TIME_W-1:0]    now_time_i,
  input  logic                          busy_i,
  input  logic                          pop_i,
  output lpad_pkg::lpad_head_t          head_o
);
  import lpad_pkg::*;

  lpad_item_t  fifo_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        push;
  logic        pop;
  lpad_item_t  new_item;

  // Classify the incoming beat.
  always_comb begin
    new_item.is_clear = req_type_i;
    new_item.call     = syscall_num_i;
    new_item.now      = now_time_i;
  end

  // Nothing enters while the table clearing pass runs.
  assign in_ready_o = (count_q != 2'd2) && !busy_i;
  assign push       = in_valid_i && in_ready_o;
  assign pop        = pop_i && (count_q != 2'd0);

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= new_item;
    end
  end

  assign head_o.valid = (count_q != 2'd0);
  assign head_o.item  = fifo_q[rd_ptr_q];

endmodule

// ----- rtl/lpad_engine.sv -----
// Back end: call window, pair table memory, training and normal-mode sequencer.
module lpad_engine #(
  parameter int unsigned SEQ_LEN   = 9,
  parameter int unsigned NUM_CALLS = 512
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lpad_pkg::lpad_cfg_t         cfg_i,
  input  lpad_pkg::lpad_head_t        head_i,
  output logic                        pop_o,
  output logic                        busy_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [lpad_pkg::MISS_W-1:0] mismatch_count_o,
  output logic                        anomaly_flag_o,
  output logic                        normal_mode_o,
  output logic                        frozen_flag_o
);
  import lpad_pkg::*;

  localparam int unsigned CALL_W      = $clog2(NUM_CALLS);
  localparam int unsigned TABLE_DEPTH = NUM_CALLS * NUM_CALLS;
  localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned BITS_W      = SEQ_LEN - 1;
  localparam int unsigned IDX_W       = $clog2(SEQ_LEN + 1);
  localparam int unsigned SLOT_W      = $clog2(SEQ_LEN);
  localparam int unsigned RED_W       = SYSCALL_W + CALL_W + 1;
  localparam int unsigned RCP_SH      = 20;
  localparam int unsigned RCP_W       = RCP_SH + 1;
  localparam int unsigned RPROD_W     = SYSCALL_W + RCP_W;
  localparam logic [RCP_W-1:0]  RCP_MUL   = RCP_W'((1 << RCP_SH) / NUM_CALLS);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_DEPTH - 1);

  lpad_state_e state_q, state_d;

  // Pair table memory.
  logic [BITS_W-1:0] mem [TABLE_DEPTH];
  logic [BITS_W-1:0] rd_data_q;
  logic              mem_rd;
  logic              mem_wr;
  logic [ADDR_W-1:0] mem_addr;
  logic [BITS_W-1:0] mem_wdata;

  // Call window.
  logic [CALL_W-1:0] win_q  [SEQ_LEN];
  logic [SEQ_LEN-1:0] full_q;
  logic [FILL_W-1:0] fill_q;

  // Per-item working registers.
  logic [ADDR_W-1:0]    clr_q;
  logic [RED_W-1:0]     red_q;
  logic [TIME_W-1:0]    now_q;
  logic [ADDR_W-1:0]    base_q;
  logic [IDX_W-1:0]     idx_q;
  logic [MISS_W-1:0]    miss_q;
  logic                 flag_q;
  logic [PROD_W-1:0]    prod_a_q;
  logic [PROD_W-1:0]    prod_b_q;
  logic                 n_nz_q;

  // Profile state.
  logic [CNT_W-1:0]  train_q;
  logic [CNT_W-1:0]  since_q;
  logic [CNT_W-1:0]  anom_q;
  logic              normal_q;
  logic              frozen_q;
  logic [TIME_W-1:0] deadline_q;

  // Result register.
  logic              out_valid_q;
  logic [MISS_W-1:0] out_miss_q;
  logic              out_flag_q;
  logic              out_normal_q;
  logic              out_frozen_q;

  logic                 out_free;
  logic                 out_load;
  logic                 slot_live;
  logic [SLOT_W-1:0]    slot;
  logic [BITS_W-1:0]    bit_mask;
  logic [RPROD_W-1:0]   red_prod;
  logic [SYSCALL_W-1:0] red_quo;
  logic [RED_W-1:0]     red_rem;
  logic [RED_W-1:0]     red_fix;
  logic [CNT_W:0]       anom_sum;
  logic [CNT_W:0]       train_sum;
  logic [CNT_W:0]       since_sum;
  logic [CNT_W-1:0]     n_val;
  logic [TIME_W:0]      dl_sum;

  assign out_free  = !out_valid_q || out_ready_i;
  assign out_load  = (state_q == ST_DEADLINE) ||
                     ((state_q == ST_IDLE) && head_i.valid && out_free && head_i.item.is_clear);
  assign slot      = idx_q[SLOT_W-1:0];
  assign slot_live = (idx_q < IDX_W'(SEQ_LEN)) && full_q[slot];
  assign bit_mask  = BITS_W'(1) << (idx_q - IDX_W'(1));
  assign anom_sum  = {1'b0, anom_q} + (CNT_W + 1)'(miss_q);
  assign train_sum = {1'b0, train_q} + (CNT_W + 1)'(1);
  assign since_sum = {1'b0, since_q} + (CNT_W + 1)'(1);
  assign n_val     = (train_q > since_q) ? (train_q - since_q) : '0;
  assign dl_sum    = {1'b0, now_q} + (TIME_W + 1)'(cfg_i.wait_ns);

  // Call number modulo NUM_CALLS: the reciprocal estimate of the quotient
  // is exact or one low, so a single compare and subtract finishes it.
  assign red_prod = RPROD_W'(red_q[SYSCALL_W-1:0]) * RPROD_W'(RCP_MUL);
  assign red_quo  = red_prod[RCP_SH +: SYSCALL_W];
  assign red_rem  = red_q - RED_W'(red_quo) * RED_W'(NUM_CALLS);
  assign red_fix  = (red_rem >= RED_W'(NUM_CALLS)) ? (red_rem - RED_W'(NUM_CALLS)) : red_rem;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:    if (clr_q == LAST_ADDR) state_d = ST_IDLE;
      ST_IDLE: begin
        if (head_i.valid && out_free && !head_i.item.is_clear) state_d = ST_REDUCE;
      end
      ST_REDUCE:   state_d = ST_SHIFT;
      ST_SHIFT:    state_d = ST_CNT_RD;
      ST_CNT_RD:   state_d = slot_live ? ST_CNT_CHK : ST_CHECK;
      ST_CNT_CHK:  state_d = ST_CNT_RD;
      ST_CHECK: begin
        if (miss_q != '0) begin
          state_d = (fill_q > FILL_W'(1)) ? ST_LRN_RD : ST_DEADLINE;
        end else begin
          state_d = frozen_q ? ST_DEADLINE : ST_MUL;
        end
      end
      ST_LRN_RD:   state_d = slot_live ? ST_LRN_WR : ST_DEADLINE;
      ST_LRN_WR:   state_d = ST_LRN_RD;
      ST_MUL:      state_d = ST_FREEZE;
      ST_FREEZE:   state_d = ST_DEADLINE;
      ST_DEADLINE: state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Memory port and queue controls.
  always_comb begin
    mem_rd    = 1'b0;
    mem_wr    = 1'b0;
    mem_addr  = base_q + ADDR_W'(win_q[slot]);
    mem_wdata = rd_data_q | bit_mask;
    pop_o     = 1'b0;
    busy_o    = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        busy_o    = 1'b1;
        mem_wr    = 1'b1;
        mem_addr  = clr_q;
        mem_wdata = '0;
      end
      ST_IDLE:   pop_o  = head_i.valid && out_free;
      ST_CNT_RD: mem_rd = slot_live;
      ST_LRN_RD: mem_rd = slot_live;
      ST_LRN_WR: mem_wr = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_wr) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_rd) begin
      rd_data_q <= mem[mem_addr];
    end
  end

  // Sequencer, window and profile registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      full_q       <= '0;
      fill_q       <= '0;
      train_q      <= '0;
      since_q      <= '0;
      anom_q       <= '0;
      normal_q     <= 1'b0;
      frozen_q     <= 1'b0;
      deadline_q   <= '0;
      out_valid_q  <= 1'b0;
      idx_q        <= '0;
      miss_q       <= '0;
      flag_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: clr_q <= clr_q + ADDR_W'(1);
        ST_IDLE: begin
          if (head_i.valid && out_free) begin
            if (head_i.item.is_clear) begin
              full_q       <= '0;
              fill_q       <= '0;
              out_miss_q   <= '0;
              out_flag_q   <= 1'b0;
              out_normal_q <= normal_q;
              out_frozen_q <= frozen_q;
            end else begin
              red_q <= RED_W'(head_i.item.call);
              now_q <= head_i.item.now;
            end
          end
        end
        ST_REDUCE: red_q <= red_fix;
        ST_SHIFT: begin
          for (int unsigned i = SEQ_LEN - 1; i > 0; i--) begin
            win_q[i] <= win_q[i-1];
          end
          win_q[0] <= CALL_W'(red_q);
          full_q   <= {full_q[SEQ_LEN-2:0], 1'b1};
          if (fill_q != '1) begin
            fill_q <= fill_q + FILL_W'(1);
          end
          base_q <= ADDR_W'(red_q) * ADDR_W'(NUM_CALLS);
          idx_q  <= IDX_W'(1);
          miss_q <= '0;
          flag_q <= 1'b0;
        end
        ST_CNT_CHK: begin
          if ((rd_data_q & bit_mask) == '0) begin
            miss_q <= miss_q + MISS_W'(1);
          end
          idx_q <= idx_q + IDX_W'(1);
        end
        ST_CHECK: begin
          // Normal-mode check, then the training counters.
          if (normal_q && miss_q != '0) begin
            flag_q <= 1'b1;
            if (anom_q > CNT_W'(cfg_i.limit)) begin
              normal_q <= 1'b0;
            end
            anom_q <= anom_sum[CNT_W] ? '1 : anom_sum[CNT_W-1:0];
          end
          train_q <= train_sum[CNT_W] ? '1 : train_sum[CNT_W-1:0];
          if (miss_q != '0) begin
            frozen_q <= 1'b0;
            since_q  <= '0;
          end else begin
            since_q <= since_sum[CNT_W] ? '1 : since_sum[CNT_W-1:0];
          end
          idx_q <= IDX_W'(1);
        end
        ST_LRN_WR: idx_q <= idx_q + IDX_W'(1);
        ST_MUL: begin
          prod_a_q <= PROD_W'(train_q) * PROD_W'(cfg_i.factor_den);
          prod_b_q <= PROD_W'(n_val) * PROD_W'(cfg_i.factor);
          n_nz_q   <= (n_val != '0);
        end
        ST_FREEZE: begin
          if (n_nz_q && prod_a_q > prod_b_q) begin
            frozen_q   <= 1'b1;
            deadline_q <= dl_sum[TIME_W] ? '1 : dl_sum[TIME_W-1:0];
          end
        end
        ST_DEADLINE: begin
          out_miss_q   <= miss_q;
          out_flag_q   <= flag_q;
          if (frozen_q && now_q > deadline_q) begin
            normal_q     <= 1'b1;
            frozen_q     <= 1'b0;
            anom_q       <= '0;
            since_q      <= '0;
            out_normal_q <= 1'b1;
            out_frozen_q <= 1'b0;
          end else begin
            out_normal_q <= normal_q;
            out_frozen_q <= frozen_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign mismatch_count_o = out_miss_q;
  assign anomaly_flag_o   = out_flag_q;
  assign normal_mode_o    = out_normal_q;
  assign frozen_flag_o    = out_frozen_q;

endmodule
